FILE: rtl/core/sps_pkg.sv
// ---------------------------------------------------------------------------
// sps_pkg: shared types and constants for the stroke polyline simplifier
// Point and result formats, register map codes and the serial MAC operand
// widths used by the controller, the MAC and the top level.
// ---------------------------------------------------------------------------
package sps_pkg;

    localparam int COORD_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int DIGIT_BITS = 4;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam int OP_W   = (2 * COORD_BITS + 1 > 2 * CFG_BITS) ?
                            2 * COORD_BITS + 1 : 2 * CFG_BITS;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [CFG_BITS-1:0] MIN_SPACING_RST = '0;
    localparam logic [CFG_BITS-1:0] LINE_TOL_RST    = CFG_BITS'(16);

    localparam logic CFG_MIN_SPACING = 1'b0;
    localparam logic CFG_LINE_TOL    = 1'b1;

    localparam logic [1:0] KEPT_NONE = 2'd0;
    localparam logic [1:0] KEPT_ONE  = 2'd1;
    localparam logic [1:0] KEPT_TWO  = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   diff_t;
    typedef logic [COORD_BITS-1:0]        mag_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   end_of_stroke;
    } sps_in_t;

    typedef struct packed {
        coord_t anchor_out_x;
        coord_t anchor_out_y;
        logic   last_in_run;
        logic   path_done;
    } sps_out_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] min_spacing;
        logic [CFG_BITS-1:0] line_tolerance;
    } sps_cfg_t;

    typedef struct packed {
        logic            start;
        logic            clear;
        logic            neg;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } sps_mac_req_t;

    typedef struct packed {
        logic     load;
        logic [1:0] count;
        sps_out_t first;
        sps_out_t second;
    } sps_emit_t;

    function automatic diff_t sps_diff(coord_t p, coord_t q);
        return diff_t'({p[COORD_BITS-1], p}) - diff_t'({q[COORD_BITS-1], q});
    endfunction

    function automatic mag_t sps_mag(diff_t d);
        diff_t n;
        n = -d;
        return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
    endfunction

endpackage

FILE: rtl/core/sps_cfg.sv
// ---------------------------------------------------------------------------
// sps_cfg: configuration registers
// APB-style register file holding the minimum spacing and line tolerance.
// ---------------------------------------------------------------------------
module sps_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sps_pkg::PADDR_W-1:0]   paddr,
    input  logic [sps_pkg::PDATA_W-1:0]   pwdata,
    output logic [sps_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output sps_pkg::sps_cfg_t             cfg
);

    logic [sps_pkg::CFG_BITS-1:0] min_spacing_reg, min_spacing_next;
    logic [sps_pkg::CFG_BITS-1:0] line_tol_reg, line_tol_next;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        min_spacing_next = min_spacing_reg;
        line_tol_next    = line_tol_reg;
        if (wr_en) begin
            unique case (paddr[2])
                sps_pkg::CFG_MIN_SPACING: begin
                    min_spacing_next = pwdata[sps_pkg::CFG_BITS-1:0];
                end
                sps_pkg::CFG_LINE_TOL: begin
                    line_tol_next = pwdata[sps_pkg::CFG_BITS-1:0];
                end
                default: begin
                    min_spacing_next = min_spacing_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_spacing_reg <= sps_pkg::MIN_SPACING_RST;
            line_tol_reg    <= sps_pkg::LINE_TOL_RST;
        end else begin
            min_spacing_reg <= min_spacing_next;
            line_tol_reg    <= line_tol_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            sps_pkg::CFG_MIN_SPACING: begin
                prdata = {{(sps_pkg::PDATA_W-sps_pkg::CFG_BITS){1'b0}}, min_spacing_reg};
            end
            sps_pkg::CFG_LINE_TOL: begin
                prdata = {{(sps_pkg::PDATA_W-sps_pkg::CFG_BITS){1'b0}}, line_tol_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.min_spacing    = min_spacing_reg;
    assign cfg.line_tolerance = line_tol_reg;

endmodule

FILE: rtl/core/sps_mac.sv
// ---------------------------------------------------------------------------
// sps_mac: digit-serial multiply-accumulate
// Retires one 4-bit digit of operand b per cycle into a signed accumulator;
// stops as soon as the remaining digits of b are zero.
// ---------------------------------------------------------------------------
module sps_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sps_pkg::sps_mac_req_t              req,
    output logic                               busy,
    output logic signed [sps_pkg::ACC_W-1:0]   acc
);

    logic                                    busy_reg, busy_next;
    logic [sps_pkg::PROD_W-1:0]              a_reg, a_next;
    logic [sps_pkg::OP_W-1:0]                b_reg, b_next;
    logic [sps_pkg::OP_W-1:0]                b_rest;
    logic                                    neg_reg, neg_next;
    logic signed [sps_pkg::ACC_W-1:0]        acc_reg, acc_next;
    logic [sps_pkg::DIGIT_BITS-1:0]          digit;
    logic [sps_pkg::PROD_W+sps_pkg::DIGIT_BITS-1:0] term_full;
    logic signed [sps_pkg::ACC_W-1:0]        term;

    assign digit     = b_reg[sps_pkg::DIGIT_BITS-1:0];
    assign b_rest    = b_reg >> sps_pkg::DIGIT_BITS;
    assign term_full = {{sps_pkg::DIGIT_BITS{1'b0}}, a_reg}
                     * {{sps_pkg::PROD_W{1'b0}}, digit};
    assign term      = $signed({1'b0, term_full[sps_pkg::PROD_W-1:0]});

    always_comb begin
        busy_next = busy_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            a_next    = {{(sps_pkg::PROD_W-sps_pkg::OP_W){1'b0}}, req.a};
            b_next    = req.b;
            neg_next  = req.neg;
            acc_next  = req.clear ? '0 : acc_reg;
            busy_next = (req.b != '0);
        end else if (busy_reg) begin
            acc_next  = neg_reg ? acc_reg - term : acc_reg + term;
            a_next    = a_reg << sps_pkg::DIGIT_BITS;
            b_next    = b_rest;
            busy_next = (b_rest != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

FILE: rtl/core/sps_ctrl.sv
// ---------------------------------------------------------------------------
// sps_ctrl: point sequencer
// Holds anchor, candidate and kept count, steps the serial MAC through the
// spacing and corner tests and hands finished results to the output buffer.
// ---------------------------------------------------------------------------
module sps_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sps_pkg::sps_in_t                   s_data,
    input  sps_pkg::sps_cfg_t                  cfg,
    input  logic                               out_empty,
    output sps_pkg::sps_mac_req_t              mac_req,
    input  logic                               mac_busy,
    input  logic signed [sps_pkg::ACC_W-1:0]   mac_acc,
    output sps_pkg::sps_emit_t                 emit
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef enum logic [9:0] {
        STEP_SQ_DX = 10'b00_0000_0001,
        STEP_SQ_DY = 10'b00_0000_0010,
        STEP_SQ_MS = 10'b00_0000_0100,
        STEP_CR_A  = 10'b00_0000_1000,
        STEP_CR_B  = 10'b00_0001_0000,
        STEP_LN_X  = 10'b00_0010_0000,
        STEP_LN_Y  = 10'b00_0100_0000,
        STEP_TOL   = 10'b00_1000_0000,
        STEP_RHS   = 10'b01_0000_0000,
        STEP_LHS   = 10'b10_0000_0000
    } step_t;

    state_t                    state_reg, state_next;
    step_t                     step_reg, step_next;
    logic [1:0]                kept_reg, kept_next;
    logic                      has_a_reg, has_a_next;
    sps_pkg::sps_in_t          item_reg, item_next;
    sps_pkg::coord_t           anchor_x_reg, anchor_x_next;
    sps_pkg::coord_t           anchor_y_reg, anchor_y_next;
    sps_pkg::coord_t           pending_x_reg, pending_x_next;
    sps_pkg::coord_t           pending_y_reg, pending_y_next;
    sps_pkg::coord_t           ra_x_reg, ra_x_next;
    sps_pkg::coord_t           ra_y_reg, ra_y_next;
    logic [sps_pkg::OP_W-1:0]  crs_reg, crs_next;
    logic [sps_pkg::OP_W-1:0]  len2_reg, len2_next;
    logic [sps_pkg::OP_W-1:0]  tol2_reg, tol2_next;

    sps_pkg::diff_t            dx, dy, ax, ay, u, v;
    logic                      acc_neg;
    logic [sps_pkg::ACC_W-1:0] acc_abs;
    logic                      eos_emit;
    sps_pkg::sps_out_t         res_a, res_e;

    assign dx = sps_pkg::sps_diff(item_reg.point_x, pending_x_reg);
    assign dy = sps_pkg::sps_diff(item_reg.point_y, pending_y_reg);
    assign ax = sps_pkg::sps_diff(item_reg.point_x, anchor_x_reg);
    assign ay = sps_pkg::sps_diff(item_reg.point_y, anchor_y_reg);
    assign u  = sps_pkg::sps_diff(anchor_y_reg, pending_y_reg);
    assign v  = sps_pkg::sps_diff(anchor_x_reg, pending_x_reg);

    assign acc_neg = mac_acc[sps_pkg::ACC_W-1];
    assign acc_abs = acc_neg ? -mac_acc : mac_acc;

    // operand selection for the current MAC step
    always_comb begin
        mac_req.start = (state_reg == ST_ISSUE);
        mac_req.clear = 1'b0;
        mac_req.neg   = 1'b0;
        mac_req.a     = '0;
        mac_req.b     = '0;
        unique case (step_reg)
            STEP_SQ_DX: begin
                mac_req.clear = 1'b1;
                mac_req.a     = sps_pkg::OP_W'(sps_pkg::sps_mag(dx));
                mac_req.b     = sps_pkg::OP_W'(sps_pkg::sps_mag(dx));
            end
            STEP_SQ_DY: begin
                mac_req.a = sps_pkg::OP_W'(sps_pkg::sps_mag(dy));
                mac_req.b = sps_pkg::OP_W'(sps_pkg::sps_mag(dy));
            end
            STEP_SQ_MS: begin
                mac_req.neg = 1'b1;
                mac_req.a   = sps_pkg::OP_W'(cfg.min_spacing);
                mac_req.b   = sps_pkg::OP_W'(cfg.min_spacing);
            end
            STEP_CR_A: begin
                mac_req.clear = 1'b1;
                mac_req.neg   = ax[sps_pkg::COORD_BITS] ^ u[sps_pkg::COORD_BITS];
                mac_req.a     = sps_pkg::OP_W'(sps_pkg::sps_mag(ax));
                mac_req.b     = sps_pkg::OP_W'(sps_pkg::sps_mag(u));
            end
            STEP_CR_B: begin
                mac_req.neg = ~(v[sps_pkg::COORD_BITS] ^ ay[sps_pkg::COORD_BITS]);
                mac_req.a   = sps_pkg::OP_W'(sps_pkg::sps_mag(v));
                mac_req.b   = sps_pkg::OP_W'(sps_pkg::sps_mag(ay));
            end
            STEP_LN_X: begin
                mac_req.clear = 1'b1;
                mac_req.a     = sps_pkg::OP_W'(sps_pkg::sps_mag(ax));
                mac_req.b     = sps_pkg::OP_W'(sps_pkg::sps_mag(ax));
            end
            STEP_LN_Y: begin
                mac_req.a = sps_pkg::OP_W'(sps_pkg::sps_mag(ay));
                mac_req.b = sps_pkg::OP_W'(sps_pkg::sps_mag(ay));
            end
            STEP_TOL: begin
                mac_req.clear = 1'b1;
                mac_req.a     = sps_pkg::OP_W'(cfg.line_tolerance);
                mac_req.b     = sps_pkg::OP_W'(cfg.line_tolerance);
            end
            STEP_RHS: begin
                mac_req.clear = 1'b1;
                mac_req.a     = len2_reg;
                mac_req.b     = tol2_reg;
            end
            STEP_LHS: begin
                mac_req.neg = 1'b1;
                mac_req.a   = crs_reg;
                mac_req.b   = crs_reg;
            end
            default: begin
                mac_req.clear = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        kept_next      = kept_reg;
        has_a_next     = has_a_reg;
        item_next      = item_reg;
        anchor_x_next  = anchor_x_reg;
        anchor_y_next  = anchor_y_reg;
        pending_x_next = pending_x_reg;
        pending_y_next = pending_y_reg;
        ra_x_next      = ra_x_reg;
        ra_y_next      = ra_y_reg;
        crs_next       = crs_reg;
        len2_next      = len2_reg;
        tol2_next      = tol2_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    has_a_next = 1'b0;
                    if (kept_reg == sps_pkg::KEPT_NONE) begin
                        anchor_x_next  = s_data.point_x;
                        anchor_y_next  = s_data.point_y;
                        pending_x_next = s_data.point_x;
                        pending_y_next = s_data.point_y;
                        kept_next      = sps_pkg::KEPT_ONE;
                        state_next     = ST_EMIT;
                    end else begin
                        step_next  = STEP_SQ_DX;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (!mac_busy) begin
                    state_next = ST_ISSUE;
                    unique case (step_reg)
                        STEP_SQ_DX: begin
                            step_next = STEP_SQ_DY;
                        end
                        STEP_SQ_DY: begin
                            step_next = STEP_SQ_MS;
                        end
                        STEP_SQ_MS: begin
                            if (acc_neg) begin
                                state_next = ST_EMIT;
                            end else if (kept_reg == sps_pkg::KEPT_ONE) begin
                                has_a_next     = 1'b1;
                                ra_x_next      = anchor_x_reg;
                                ra_y_next      = anchor_y_reg;
                                kept_next      = sps_pkg::KEPT_TWO;
                                pending_x_next = item_reg.point_x;
                                pending_y_next = item_reg.point_y;
                                state_next     = ST_EMIT;
                            end else if (ax == '0 && ay == '0) begin
                                pending_x_next = item_reg.point_x;
                                pending_y_next = item_reg.point_y;
                                state_next     = ST_EMIT;
                            end else begin
                                step_next = STEP_CR_A;
                            end
                        end
                        STEP_CR_A: begin
                            step_next = STEP_CR_B;
                        end
                        STEP_CR_B: begin
                            crs_next  = acc_abs[sps_pkg::OP_W-1:0];
                            step_next = STEP_LN_X;
                        end
                        STEP_LN_X: begin
                            step_next = STEP_LN_Y;
                        end
                        STEP_LN_Y: begin
                            len2_next = mac_acc[sps_pkg::OP_W-1:0];
                            step_next = STEP_TOL;
                        end
                        STEP_TOL: begin
                            tol2_next = mac_acc[sps_pkg::OP_W-1:0];
                            step_next = STEP_RHS;
                        end
                        STEP_RHS: begin
                            step_next = STEP_LHS;
                        end
                        STEP_LHS: begin
                            if (acc_neg) begin
                                has_a_next    = 1'b1;
                                ra_x_next     = pending_x_reg;
                                ra_y_next     = pending_y_reg;
                                anchor_x_next = pending_x_reg;
                                anchor_y_next = pending_y_reg;
                            end
                            pending_x_next = item_reg.point_x;
                            pending_y_next = item_reg.point_y;
                            state_next     = ST_EMIT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_empty) begin
                    if (item_reg.end_of_stroke) begin
                        kept_next = sps_pkg::KEPT_NONE;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_SQ_DX;
            kept_reg      <= sps_pkg::KEPT_NONE;
            has_a_reg     <= 1'b0;
            anchor_x_reg  <= '0;
            anchor_y_reg  <= '0;
            pending_x_reg <= '0;
            pending_y_reg <= '0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            kept_reg      <= kept_next;
            has_a_reg     <= has_a_next;
            anchor_x_reg  <= anchor_x_next;
            anchor_y_reg  <= anchor_y_next;
            pending_x_reg <= pending_x_next;
            pending_y_reg <= pending_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        ra_x_reg <= ra_x_next;
        ra_y_reg <= ra_y_next;
        crs_reg  <= crs_next;
        len2_reg <= len2_next;
        tol2_reg <= tol2_next;
    end

    // corner or first point, then the closing point of the stroke
    assign eos_emit = item_reg.end_of_stroke && (kept_reg == sps_pkg::KEPT_TWO);

    assign res_a.anchor_out_x = ra_x_reg;
    assign res_a.anchor_out_y = ra_y_reg;
    assign res_a.last_in_run  = ~eos_emit;
    assign res_a.path_done    = 1'b0;

    assign res_e.anchor_out_x = pending_x_reg;
    assign res_e.anchor_out_y = pending_y_reg;
    assign res_e.last_in_run  = 1'b1;
    assign res_e.path_done    = 1'b1;

    assign emit.load   = (state_reg == ST_EMIT) && out_empty;
    assign emit.count  = {1'b0, has_a_reg} + {1'b0, eos_emit};
    assign emit.first  = has_a_reg ? res_a : res_e;
    assign emit.second = res_e;

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/core/stroke_polyline_simplifier.sv
// ---------------------------------------------------------------------------
// stroke_polyline_simplifier: stroke point corner finder
// Keeps stroke points that clear the minimum spacing and emits a candidate
// as a corner when it lies farther than the tolerance from the chord.
//
//   channel   ports                      carries
//   input     s_valid s_ready s_data     one stroke point per item
//   result    m_valid m_ready m_data     zero, one or two anchors per point
//   config    psel penable pwrite ...    min_spacing at 0, line_tolerance at 4
//
// One point at a time. The serial MAC retires 4 bits of one operand per cycle
// and ends early on leading zero digits; the sequencer issues each MAC step
// and waits until the MAC is idle. Results wait in a two-entry output buffer,
// so a stalled result side blocks the next point only when it finishes.
// Reset is synchronous and clears the control state, kept count and anchors.
// ---------------------------------------------------------------------------
module stroke_polyline_simplifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sps_pkg::sps_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sps_pkg::sps_out_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sps_pkg::PADDR_W-1:0]   paddr,
    input  logic [sps_pkg::PDATA_W-1:0]   pwdata,
    output logic [sps_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    sps_pkg::sps_cfg_t                 cfg;
    sps_pkg::sps_mac_req_t             mac_req;
    logic                              mac_busy;
    logic signed [sps_pkg::ACC_W-1:0]  mac_acc;
    sps_pkg::sps_emit_t                emit;
    logic                              out_empty;
    logic                              pop;

    logic [1:0]                        cnt_reg, cnt_next;
    sps_pkg::sps_out_t                 slot0_reg, slot0_next;
    sps_pkg::sps_out_t                 slot1_reg, slot1_next;

    sps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sps_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mac_req),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    sps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg),
        .out_empty (out_empty),
        .mac_req   (mac_req),
        .mac_busy  (mac_busy),
        .mac_acc   (mac_acc),
        .emit      (emit)
    );

    assign out_empty = (cnt_reg == 2'd0);
    assign m_valid   = ~out_empty;
    assign m_data    = slot0_reg;
    assign pop       = m_valid & m_ready;

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (emit.load) begin
            cnt_next   = emit.count;
            slot0_next = emit.first;
            slot1_next = emit.second;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.load |-> !m_valid)
        else $error("results loaded over an occupied output buffer");

    a_ready_mac_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mac_busy)
        else $error("input ready while the MAC is still running");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.load && emit.count == 2'd2 |=> m_valid && !m_data.last_in_run)
        else $error("first of two results marked as last");

endmodule
